[rtl/core/sfr_pkg.sv]
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants of the streaming find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_FIND_PATTERN    = 3'd0,
    REG_FIND_LENGTH     = 3'd1,
    REG_REPLACE_PATTERN = 3'd2,
    REG_REPLACE_LENGTH  = 3'd3,
    REG_IGNORE_COUNT    = 3'd4,
    REG_REPLACE_LIMIT   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [63:0] find_pattern;
    logic [3:0]  find_length;
    logic [63:0] replace_pattern;
    logic [3:0]  replace_length;
    logic [15:0] ignore_count;
    logic [15:0] replace_limit;
  } cfg_t;

  typedef struct packed {
    logic        ignore_load;
    logic        limit_load;
    logic [15:0] value;
  } ctr_load_t;

endpackage

[rtl/core/sfr_front.sv]
// ----------------------------------------------------------------------------
// sfr_front
// Match window and counters: accepts source bytes and turns each that releases
// results or ends the string into a descriptor of the result bytes it releases.
// ----------------------------------------------------------------------------
module sfr_front import sfr_pkg::*; #(
  parameter int MaxPattern = MAX_PATTERN,
  localparam int CW = $clog2(MaxPattern + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cfg_t                    cfg,
  input  ctr_load_t               ctr_load,
  input  logic                    take,
  input  logic [7:0]              in_byte,
  input  logic                    end_of_string,
  output logic                    push,
  output logic [MaxPattern*8-1:0] d_bytes,
  output logic [CW-1:0]           d_pre,
  output logic [CW-1:0]           d_cnt,
  output logic                    d_repl,
  output logic                    d_eos
);

  logic [7:0]            win      [MaxPattern];
  logic [7:0]            win_next [MaxPattern];
  logic [7:0]            ext      [MaxPattern];
  logic [CW-1:0]         fill, fill_next;
  logic [15:0]           ignores_left, replacements_left;
  logic [CW-1:0]         nf, flen, rlen, k_sel, m, cnt;
  logic [CW:0]           total;
  logic [MaxPattern-1:0] ok;
  logic                  hit, repl, dec_ign, dec_rep;

  always_comb begin
    if (cfg.find_length == 4'd0) begin
      flen = CW'(1);
    end else if (cfg.find_length > 4'(MaxPattern)) begin
      flen = CW'(MaxPattern);
    end else begin
      flen = CW'(cfg.find_length);
    end
    if (cfg.replace_length > 4'(MaxPattern)) begin
      rlen = CW'(MaxPattern);
    end else begin
      rlen = CW'(cfg.replace_length);
    end
  end

  // append the new byte behind the held window
  always_comb begin
    nf = fill + CW'(1);
    for (int i = 0; i < MaxPattern; i++) begin
      if (CW'(i) < fill) begin
        ext[i] = win[i];
      end else if (CW'(i) == fill) begin
        ext[i] = in_byte;
      end else begin
        ext[i] = 8'h00;
      end
    end
  end

  // a shift k is good when what remains is a prefix of the pattern
  always_comb begin
    for (int k = 0; k < MaxPattern; k++) begin
      ok[k] = (CW'(k) < nf) && ((nf - CW'(k)) <= flen);
      for (int i = 0; i < MaxPattern; i++) begin
        if (k + i < MaxPattern) begin
          if ((CW'(k + i) < nf) && (ext[k + i] != cfg.find_pattern[8*i +: 8])) begin
            ok[k] = 1'b0;
          end
        end
      end
    end
  end

  // release bytes up to the leftmost good shift
  always_comb begin
    k_sel = nf;
    for (int k = MaxPattern - 1; k >= 0; k--) begin
      if (ok[k]) begin
        k_sel = CW'(k);
      end
    end
    m   = nf - k_sel;
    hit = (m == flen);
  end

  always_comb begin
    repl    = 1'b0;
    dec_ign = 1'b0;
    dec_rep = 1'b0;
    if (hit) begin
      priority if (ignores_left != 16'd0) begin
        dec_ign = 1'b1;
      end else if (cfg.replace_limit == 16'd0) begin
        repl = 1'b1;
      end else if (replacements_left != 16'd0) begin
        dec_rep = 1'b1;
        repl    = 1'b1;
      end else begin
        // limit spent: pass the match through
        repl = 1'b0;
      end
    end
  end

  always_comb begin
    if (repl) begin
      total = {1'b0, k_sel} + {1'b0, rlen};
    end else if (hit || end_of_string) begin
      total = {1'b0, k_sel} + {1'b0, m};
    end else begin
      total = {1'b0, k_sel};
    end
    // drop anything beyond one window's worth of results
    cnt = (total > (CW + 1)'(MaxPattern)) ? CW'(MaxPattern) : total[CW-1:0];
  end

  always_comb begin
    for (int i = 0; i < MaxPattern; i++) begin
      win_next[i] = 8'h00;
      for (int k = 0; k < MaxPattern; k++) begin
        if ((i + k < MaxPattern) && (CW'(k) == k_sel)) begin
          win_next[i] = ext[i + k];
        end
      end
    end
    fill_next = (hit || end_of_string) ? '0 : m;
  end

  always_comb begin
    push = take && ((cnt != '0) || end_of_string);
    for (int i = 0; i < MaxPattern; i++) begin
      d_bytes[8*i +: 8] = ext[i];
    end
    d_pre  = k_sel;
    d_cnt  = cnt;
    d_repl = repl;
    d_eos  = end_of_string;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill              <= '0;
      ignores_left      <= 16'd0;
      replacements_left <= 16'd0;
    end else begin
      if (take) begin
        fill <= fill_next;
        if (end_of_string) begin
          ignores_left      <= cfg.ignore_count;
          replacements_left <= cfg.replace_limit;
        end else begin
          if (dec_ign) begin
            ignores_left <= ignores_left - 16'd1;
          end
          if (dec_rep) begin
            replacements_left <= replacements_left - 16'd1;
          end
        end
      end
      if (ctr_load.ignore_load) begin
        ignores_left <= ctr_load.value;
      end
      if (ctr_load.limit_load) begin
        replacements_left <= ctr_load.value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      win <= win_next;
    end
  end

endmodule

[rtl/core/sfr_queue.sv]
// ----------------------------------------------------------------------------
// sfr_queue
// Small first-in first-out queue of descriptors between front and back.
// ----------------------------------------------------------------------------
module sfr_queue import sfr_pkg::*; #(
  parameter int Width = 8,
  parameter int Depth = QUEUE_DEPTH,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             space,
  input  logic             pop,
  output logic             rvalid,
  output logic [Width-1:0] rdata
);

  logic [Width-1:0] slots [Depth];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;
  logic             do_push, do_pop;

  assign space   = (count != (AW + 1)'(Depth));
  assign rvalid  = (count != '0);
  assign rdata   = slots[rd_ptr];
  assign do_push = push && space;
  assign do_pop  = pop && rvalid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW + 1)'(do_push) - (AW + 1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wdata;
    end
  end

endmodule

[rtl/core/sfr_back.sv]
// ----------------------------------------------------------------------------
// sfr_back
// Serializer: walks the head descriptor and presents one result per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module sfr_back import sfr_pkg::*; #(
  parameter int MaxPattern = MAX_PATTERN,
  localparam int CW = $clog2(MaxPattern + 1)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    head_valid,
  input  logic [MaxPattern*8-1:0] head_bytes,
  input  logic [CW-1:0]           head_pre,
  input  logic [CW-1:0]           head_cnt,
  input  logic                    head_repl,
  input  logic                    head_eos,
  input  logic [63:0]             replace_pattern,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [7:0]              out_byte,
  output logic                    byte_valid,
  output logic                    last
);

  logic [CW-1:0] idx, idx_next, rep_idx;
  logic [7:0]    src, rep;
  logic          fire, final_beat;

  assign out_valid  = head_valid;
  assign fire       = out_valid && out_ready;
  assign final_beat = (head_cnt == '0) || (idx == head_cnt - CW'(1));
  assign pop        = fire && final_beat;
  assign rep_idx    = idx - head_pre;

  always_comb begin
    src = 8'h00;
    rep = 8'h00;
    for (int i = 0; i < MaxPattern; i++) begin
      if (CW'(i) == idx) begin
        src = head_bytes[8*i +: 8];
      end
      if (CW'(i) == rep_idx) begin
        rep = replace_pattern[8*i +: 8];
      end
    end
  end

  always_comb begin
    byte_valid = (head_cnt != '0);
    last       = head_eos && final_beat;
    priority if (head_cnt == '0) begin
      out_byte = 8'h00;
    end else if (head_repl && (idx >= head_pre)) begin
      out_byte = rep;
    end else begin
      out_byte = src;
    end
  end

  always_comb begin
    idx_next = idx;
    if (fire) begin
      idx_next = final_beat ? '0 : idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else begin
      idx <= idx_next;
    end
  end

endmodule

[rtl/core/stream_find_replace.sv]
// ----------------------------------------------------------------------------
// stream_find_replace
// Streaming find-and-replace over a byte string with configuration registers.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------
//  cfg     | cfg_write                | cfg_index, cfg_data
//  in      | in_valid / in_ready      | in_byte, end_of_string
//  out     | out_valid / out_ready    | out_byte, byte_valid, last
//
//  The front takes one byte per cycle while the queue has space; a request's
//  descriptor is registered in the queue before its results show. Each
//  request yields 0 to MaxPattern results, which the back delivers one per
//  cycle while out_ready is high; a four-entry descriptor queue sets how far
//  the front runs ahead. Sustained rate is one byte per cycle while bytes
//  release at most one result each; n replacement bytes add n results.
//  Synchronous reset empties the queue, clears the window and counters, and loads the register defaults.
// ----------------------------------------------------------------------------
module stream_find_replace import sfr_pkg::*; #(
  parameter int MaxPattern = MAX_PATTERN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last
);

  localparam int CW    = $clog2(MaxPattern + 1);
  localparam int DescW = MaxPattern * 8 + 2 * CW + 2;

  cfg_t                    cfg;
  ctr_load_t               ctr_load;
  logic                    take, push, space, pop, head_valid;
  logic [MaxPattern*8-1:0] d_bytes, head_bytes;
  logic [CW-1:0]           d_pre, d_cnt, head_pre, head_cnt;
  logic                    d_repl, d_eos, head_repl, head_eos;
  logic [DescW-1:0]        wdata, rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.find_pattern    <= 64'd0;
      cfg.find_length     <= 4'd1;
      cfg.replace_pattern <= 64'd0;
      cfg.replace_length  <= 4'd0;
      cfg.ignore_count    <= 16'd0;
      cfg.replace_limit   <= 16'd0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_FIND_PATTERN:    cfg.find_pattern    <= cfg_data;
        REG_FIND_LENGTH:     cfg.find_length     <= cfg_data[3:0];
        REG_REPLACE_PATTERN: cfg.replace_pattern <= cfg_data;
        REG_REPLACE_LENGTH:  cfg.replace_length  <= cfg_data[3:0];
        REG_IGNORE_COUNT:    cfg.ignore_count    <= cfg_data[15:0];
        REG_REPLACE_LIMIT:   cfg.replace_limit   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // counter writes also reload the running counters
  always_comb begin
    ctr_load.ignore_load = cfg_write && (cfg_index == REG_IGNORE_COUNT);
    ctr_load.limit_load  = cfg_write && (cfg_index == REG_REPLACE_LIMIT);
    ctr_load.value       = cfg_data[15:0];
  end

  assign in_ready = space;
  assign take     = in_valid && space;

  sfr_front #(.MaxPattern(MaxPattern)) u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .ctr_load      (ctr_load),
    .take          (take),
    .in_byte       (in_byte),
    .end_of_string (end_of_string),
    .push          (push),
    .d_bytes       (d_bytes),
    .d_pre         (d_pre),
    .d_cnt         (d_cnt),
    .d_repl        (d_repl),
    .d_eos         (d_eos)
  );

  assign wdata = {d_eos, d_repl, d_cnt, d_pre, d_bytes};
  assign {head_eos, head_repl, head_cnt, head_pre, head_bytes} = rdata;

  sfr_queue #(.Width(DescW), .Depth(QUEUE_DEPTH)) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wdata  (wdata),
    .space  (space),
    .pop    (pop),
    .rvalid (head_valid),
    .rdata  (rdata)
  );

  sfr_back #(.MaxPattern(MaxPattern)) u_back (
    .clk             (clk),
    .rst             (rst),
    .head_valid      (head_valid),
    .head_bytes      (head_bytes),
    .head_pre        (head_pre),
    .head_cnt        (head_cnt),
    .head_repl       (head_repl),
    .head_eos        (head_eos),
    .replace_pattern (cfg.replace_pattern),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .byte_valid      (byte_valid),
    .last            (last)
  );

endmodule

[rtl/core/sfr_checker.sv]
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks of the find-and-replace block, bound to the top level.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       last
);

  // queue starts empty after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high right after reset");

  // a bare end marker is always the last result and carries a zero byte
  a_bare_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (last && (out_byte == 8'h00)))
    else $error("bare end marker without last or with a byte");

  // a full queue always has a head to show
  a_full_has_head: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled while output is empty");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_byte) && $stable(byte_valid) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (.*);
